@@ rtl/ahd_pkg.sv @@
// shared types and constants for the angle histogram distance block
package ahd_pkg;

  // item function codes
  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_CMP = 2'd1;
  localparam logic [1:0] FUNC_CLR = 2'd2;

  // bin and weight widths
  localparam int unsigned BIN_W    = 32;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned ANGLE_W  = 16;
  localparam int unsigned IDX_W    = 8;

  // histogram sum, up to 256 bins of 32 bits
  localparam int unsigned SUM_W  = 40;
  localparam int unsigned HALF_W = SUM_W / 2;
  // one partial product: sum-wide operand times half of the other sum
  localparam int unsigned MUL_W  = SUM_W + HALF_W;
  // full product of a sum and a sum
  localparam int unsigned PROD_W = 2 * SUM_W;
  // accumulated absolute differences and the doubled denominator
  localparam int unsigned ACC_W  = PROD_W + 1;
  // quotient and shifted numerator
  localparam int unsigned QUO_W  = 17;
  localparam int unsigned NUM_W  = ACC_W + QUO_W - 1;

  // steps of the per-bin sequence
  localparam logic [2:0] PH_RD  = 3'd0;
  localparam logic [2:0] PH_MLO = 3'd1;
  localparam logic [2:0] PH_MHI = 3'd2;
  localparam logic [2:0] PH_SUM = 3'd3;
  localparam logic [2:0] PH_ABS = 3'd4;
  localparam logic [2:0] PH_ACC = 3'd5;

  // main sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_WR,
    ST_SUM,
    ST_DEN,
    ST_DIFF,
    ST_DIV_GO,
    ST_DIV,
    ST_DONE
  } st_e;

endpackage

@@ rtl/ahd_ram.sv @@
// generic single-write, single-read ram with registered read data
module ahd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held while not reading
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/ahd_div.sv @@
// restoring divider, one quotient bit per cycle
module ahd_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ahd_pkg::NUM_W-1:0]  num_i,
  input  logic [ahd_pkg::ACC_W-1:0]  den_i,
  output logic                       done_o,
  output logic [ahd_pkg::QUO_W-1:0]  quot_o
);

  localparam int unsigned CNT_W = $clog2(ahd_pkg::QUO_W);

  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [ahd_pkg::NUM_W-1:0] rem_q;
  logic [ahd_pkg::NUM_W-1:0] dsh_q;
  logic [ahd_pkg::QUO_W-1:0] quo_q;
  logic                      fits;

  assign fits = (rem_q >= dsh_q);

  // step control
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(ahd_pkg::QUO_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // remainder, shifted divisor and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dsh_q <= {den_i, {(ahd_pkg::QUO_W - 1){1'b0}}};
      quo_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - dsh_q;
      end
      quo_q <= {quo_q[ahd_pkg::QUO_W-2:0], fits};
      dsh_q <= dsh_q >> 1;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

@@ rtl/angle_histogram_distance.sv @@
// top level: two weighted angle histograms in ram with half l1 distance compare
//
//  channel | valid      | stall       | payload
//  --------+------------+-------------+--------------------------------------------
//  in      | in_valid_i | in_stall_o  | func_i, target_i, angle_i, weight_i
//  out     | out_valid_o| out_stall_i | bin_index_o, distance_o, distance_valid_o
//
// an add item: accept with bin read, then saturating write back
// clear and unused items go to the done step; clear drops the per-bin valid flags at once
// a compare item does a summing walk over the rams, a denominator multiply,
// a 6-step multiply and difference walk per bin, then a 17-step divider
// one item is in flight at a time; a result waits in the output register
// and a stalled output holds the sequencer in its last step
// reset clears the valid flags, so the ram needs no clearing pass
module angle_histogram_distance #(
  parameter int unsigned BINS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     func_i,
  input  logic                           target_i,
  input  logic [ahd_pkg::ANGLE_W-1:0]    angle_i,
  input  logic [ahd_pkg::WEIGHT_W-1:0]   weight_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [ahd_pkg::IDX_W-1:0]      bin_index_o,
  output logic [ahd_pkg::QUO_W-1:0]      distance_o,
  output logic                           distance_valid_o
);

  localparam int unsigned AW = $clog2(BINS);
  localparam int unsigned BW = $clog2(BINS + 1);
  localparam int unsigned PW = ahd_pkg::ANGLE_W + BW;

  // sequencer state
  ahd_pkg::st_e state_q, state_d;
  logic [BW-1:0] cnt_q, cnt_d;
  logic [2:0]    ph_q, ph_d;
  logic          cmp_q, cmp_d;

  // valid flags per bin
  logic [BINS-1:0] va_q, vb_q;
  logic            vra_q, vrb_q;

  // item fields
  logic                           target_q;
  logic [ahd_pkg::WEIGHT_W-1:0]   weight_q;
  logic [AW-1:0]                  bin_q;

  // compare datapath
  logic [ahd_pkg::SUM_W-1:0]  sa_q, sb_q;
  logic [ahd_pkg::MUL_W-1:0]  px_lo_q, px_hi_q, py_lo_q, py_hi_q;
  logic [ahd_pkg::PROD_W-1:0] x_q, y_q, diff_q;
  logic [ahd_pkg::ACC_W-1:0]  acc_q, den_q;
  logic [ahd_pkg::QUO_W-1:0]  dist_q;

  // output register
  logic                         out_valid_q, out_valid_d;
  logic                         out_load;
  logic [ahd_pkg::IDX_W-1:0]    out_bin_q, out_bin_d;
  logic [ahd_pkg::QUO_W-1:0]    out_dist_q, out_dist_d;
  logic                         out_dval_q, out_dval_d;
  logic                         out_free;

  // ram ports
  logic                        re;
  logic [AW-1:0]               raddr;
  logic                        we_a, we_b;
  logic [ahd_pkg::BIN_W-1:0]   rd_a, rd_b;
  logic [ahd_pkg::BIN_W-1:0]   a_val, b_val, old_val, wdata;
  logic [ahd_pkg::BIN_W:0]     sat_sum;

  // misc
  logic                        accept;
  logic                        clr_all;
  logic                        div_start, div_done;
  logic [ahd_pkg::QUO_W-1:0]   div_quot;
  logic [PW-1:0]               bin_prod;
  logic [AW-1:0]               in_bin;
  logic [ahd_pkg::SUM_W-1:0]   sa_nx, sb_nx;
  logic [ahd_pkg::SUM_W-1:0]   mx_a, my_a;
  logic [ahd_pkg::HALF_W-1:0]  mx_b, my_b;
  logic [ahd_pkg::MUL_W-1:0]   mx, my;
  logic [ahd_pkg::PROD_W-1:0]  x_c, y_c;

  assign in_stall_o = (state_q != ahd_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // bin of the incoming angle: floor(angle * BINS / 65536)
  assign bin_prod = PW'(angle_i) * PW'(BINS);
  assign in_bin   = bin_prod[ahd_pkg::ANGLE_W +: AW];

  // read data, zero for bins not written since the last clear
  assign a_val = vra_q ? rd_a : '0;
  assign b_val = vrb_q ? rd_b : '0;

  // saturating bin update
  assign old_val = target_q ? b_val : a_val;
  assign sat_sum = {1'b0, old_val} + (ahd_pkg::BIN_W + 1)'(weight_q);
  assign wdata   = sat_sum[ahd_pkg::BIN_W] ? '1 : sat_sum[ahd_pkg::BIN_W-1:0];

  // running sums
  assign sa_nx = sa_q + ahd_pkg::SUM_W'(a_val);
  assign sb_nx = sb_q + ahd_pkg::SUM_W'(b_val);

  // two multiplier lanes, each a sum-wide operand times one half of a sum
  assign mx_a = (state_q == ahd_pkg::ST_DEN) ? sa_q : ahd_pkg::SUM_W'(a_val);
  assign my_a = ahd_pkg::SUM_W'(b_val);
  assign mx_b = (ph_q == ahd_pkg::PH_MHI) ? sb_q[ahd_pkg::SUM_W-1:ahd_pkg::HALF_W]
                                           : sb_q[ahd_pkg::HALF_W-1:0];
  assign my_b = (ph_q == ahd_pkg::PH_MHI) ? sa_q[ahd_pkg::SUM_W-1:ahd_pkg::HALF_W]
                                           : sa_q[ahd_pkg::HALF_W-1:0];
  assign mx   = ahd_pkg::MUL_W'(mx_a) * ahd_pkg::MUL_W'(mx_b);
  assign my   = ahd_pkg::MUL_W'(my_a) * ahd_pkg::MUL_W'(my_b);

  // join the partial products
  assign x_c = ahd_pkg::PROD_W'(px_lo_q) + {px_hi_q, {ahd_pkg::HALF_W{1'b0}}};
  assign y_c = ahd_pkg::PROD_W'(py_lo_q) + {py_hi_q, {ahd_pkg::HALF_W{1'b0}}};

  // ram read and write control
  always_comb begin
    re    = 1'b0;
    raddr = cnt_q[AW-1:0];
    we_a  = 1'b0;
    we_b  = 1'b0;
    unique case (state_q)
      ahd_pkg::ST_IDLE: begin
        re    = accept && (func_i == ahd_pkg::FUNC_ADD);
        raddr = in_bin;
      end
      ahd_pkg::ST_ADD_WR: begin
        we_a = out_free && !target_q;
        we_b = out_free && target_q;
      end
      ahd_pkg::ST_SUM: begin
        re = (cnt_q != BW'(BINS));
      end
      ahd_pkg::ST_DIFF: begin
        re = (ph_q == ahd_pkg::PH_RD);
      end
      default: begin
        re = 1'b0;
      end
    endcase
  end

  // sequencer next state and result loading
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ph_d        = ph_q;
    cmp_d       = cmp_q;
    clr_all     = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    out_bin_d   = '0;
    out_dist_d  = '0;
    out_dval_d  = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ahd_pkg::ST_IDLE: begin
        if (accept) begin
          cmp_d = 1'b0;
          cnt_d = '0;
          ph_d  = ahd_pkg::PH_RD;
          case (func_i)
            ahd_pkg::FUNC_ADD: state_d = ahd_pkg::ST_ADD_WR;
            ahd_pkg::FUNC_CMP: begin
              cmp_d   = 1'b1;
              state_d = ahd_pkg::ST_SUM;
            end
            ahd_pkg::FUNC_CLR: begin
              clr_all = 1'b1;
              state_d = ahd_pkg::ST_DONE;
            end
            default: state_d = ahd_pkg::ST_DONE;
          endcase
        end
      end
      ahd_pkg::ST_ADD_WR: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          out_bin_d   = ahd_pkg::IDX_W'(bin_q);
          state_d     = ahd_pkg::ST_IDLE;
        end
      end
      ahd_pkg::ST_SUM: begin
        if (cnt_q == BW'(BINS)) begin
          ph_d    = ahd_pkg::PH_RD;
          state_d = ahd_pkg::ST_DEN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ahd_pkg::ST_DEN: begin
        if (ph_q == ahd_pkg::PH_ABS) begin
          ph_d    = ahd_pkg::PH_RD;
          cnt_d   = '0;
          state_d = ahd_pkg::ST_DIFF;
        end else begin
          ph_d = ph_q + 1'b1;
        end
      end
      ahd_pkg::ST_DIFF: begin
        if (ph_q == ahd_pkg::PH_ACC) begin
          ph_d = ahd_pkg::PH_RD;
          if (cnt_q == BW'(BINS - 1)) begin
            state_d = ahd_pkg::ST_DIV_GO;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end else begin
          ph_d = ph_q + 1'b1;
        end
      end
      ahd_pkg::ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = ahd_pkg::ST_DIV;
      end
      ahd_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = ahd_pkg::ST_DONE;
        end
      end
      ahd_pkg::ST_DONE: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          out_dist_d  = cmp_q ? dist_q : '0;
          out_dval_d  = cmp_q;
          state_d     = ahd_pkg::ST_IDLE;
        end
      end
      default: state_d = ahd_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ahd_pkg::ST_IDLE;
      cnt_q       <= '0;
      ph_q        <= ahd_pkg::PH_RD;
      cmp_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ph_q        <= ph_d;
      cmp_q       <= cmp_d;
      out_valid_q <= out_valid_d;
    end
  end

  // per-bin valid flags, cleared by reset and by a clear item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= '0;
      vb_q <= '0;
    end else if (clr_all) begin
      va_q <= '0;
      vb_q <= '0;
    end else begin
      if (we_a) begin
        va_q[bin_q] <= 1'b1;
      end
      if (we_b) begin
        vb_q[bin_q] <= 1'b1;
      end
    end
  end

  // valid flags follow the read data
  always_ff @(posedge clk_i) begin
    if (re) begin
      vra_q <= va_q[raddr];
      vrb_q <= vb_q[raddr];
    end
  end

  // item fields
  always_ff @(posedge clk_i) begin
    if (accept) begin
      target_q <= target_i;
      weight_q <= weight_i;
      bin_q    <= in_bin;
    end
  end

  // histogram sums, an empty histogram counts as 1
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sa_q <= '0;
      sb_q <= '0;
    end else if (state_q == ahd_pkg::ST_SUM && cnt_q != '0) begin
      if (cnt_q == BW'(BINS)) begin
        sa_q <= (sa_nx == '0) ? ahd_pkg::SUM_W'(1) : sa_nx;
        sb_q <= (sb_nx == '0) ? ahd_pkg::SUM_W'(1) : sb_nx;
      end else begin
        sa_q <= sa_nx;
        sb_q <= sb_nx;
      end
    end
  end

  // products, absolute differences and accumulation
  always_ff @(posedge clk_i) begin
    if (state_q == ahd_pkg::ST_DEN || state_q == ahd_pkg::ST_DIFF) begin
      case (ph_q)
        ahd_pkg::PH_MLO: begin
          px_lo_q <= mx;
          py_lo_q <= my;
        end
        ahd_pkg::PH_MHI: begin
          px_hi_q <= mx;
          py_hi_q <= my;
        end
        ahd_pkg::PH_SUM: begin
          x_q <= x_c;
          y_q <= y_c;
        end
        ahd_pkg::PH_ABS: begin
          if (state_q == ahd_pkg::ST_DEN) begin
            den_q <= {x_q, 1'b0};
            acc_q <= '0;
          end else begin
            diff_q <= (x_q >= y_q) ? (x_q - y_q) : (y_q - x_q);
          end
        end
        ahd_pkg::PH_ACC: begin
          acc_q <= acc_q + ahd_pkg::ACC_W'(diff_q);
        end
        default: begin
        end
      endcase
    end
  end

  // quotient capture
  always_ff @(posedge clk_i) begin
    if (div_done) begin
      dist_q <= div_quot;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_bin_q  <= out_bin_d;
      out_dist_q <= out_dist_d;
      out_dval_q <= out_dval_d;
    end
  end

  // histogram a
  ahd_ram #(
    .WIDTH (ahd_pkg::BIN_W),
    .DEPTH (BINS)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (bin_q),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rd_a)
  );

  // histogram b
  ahd_ram #(
    .WIDTH (ahd_pkg::BIN_W),
    .DEPTH (BINS)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (bin_q),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rd_b)
  );

  // 65536 * acc / (2 * sa * sb)
  ahd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({acc_q, {(ahd_pkg::QUO_W - 1){1'b0}}}),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign out_valid_o      = out_valid_q;
  assign bin_index_o      = out_bin_q;
  assign distance_o       = out_dist_q;
  assign distance_valid_o = out_dval_q;

endmodule

@@ tb/sv/angle_histogram_distance_test.sv @@
// self-checking testbench for the angle histogram distance block
`timescale 1ns / 1ps

module angle_histogram_distance_test;

  localparam int unsigned BIN_COUNT = 16;
  // no operation is defined for the last func code
  localparam logic [1:0] FUNC_NONE  = 2'd3;
  // cycles with no accepted item and no taken result before the run is given up
  localparam int unsigned STALL_LIMIT = 20000;
  // a compare walks every bin and divides, well under this
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned STEADY_ITEMS = 200;

  typedef struct {
    logic [1:0]                   func;
    logic                         target;
    logic [ahd_pkg::ANGLE_W-1:0]  angle;
    logic [ahd_pkg::WEIGHT_W-1:0] weight;
    bit                           drain;   // hold off until all results are back
    bit                           steady;  // from here on, no idling on either side
  } hist_item_t;

  typedef struct {
    logic [ahd_pkg::IDX_W-1:0] bin_index;
    logic [ahd_pkg::QUO_W-1:0] distance;
    logic                      dist_valid;
  } hist_result_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic [1:0]                   func_i = ahd_pkg::FUNC_ADD;
  logic                         target_i = 1'b0;
  logic [ahd_pkg::ANGLE_W-1:0]  angle_i = '0;
  logic [ahd_pkg::WEIGHT_W-1:0] weight_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [ahd_pkg::IDX_W-1:0]    bin_index_o;
  logic [ahd_pkg::QUO_W-1:0]    distance_o;
  logic                         distance_valid_o;

  // predicted histogram contents
  logic [ahd_pkg::BIN_W-1:0] bins_a [BIN_COUNT];
  logic [ahd_pkg::BIN_W-1:0] bins_b [BIN_COUNT];

  hist_item_t   angle_items_q [$];
  hist_result_t hist_results_q [$];

  bit          in_took = 1'b0;
  bit          steady = 1'b0;
  bit          send_idle = 1'b1;
  bit          stall_idle = 1'b1;
  int unsigned in_gap = 0;
  int unsigned stall_left = 0;
  int unsigned stall_tick = 0;
  int unsigned sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned errors = 0;
  int unsigned checked = 0;
  int unsigned n_add = 0, n_cmp = 0, n_clr = 0, n_none = 0, n_sat = 0;

  angle_histogram_distance #(
    .BINS(BIN_COUNT)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .target_i        (target_i),
    .angle_i         (angle_i),
    .weight_i        (weight_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .bin_index_o     (bin_index_o),
    .distance_o      (distance_o),
    .distance_valid_o(distance_valid_o)
  );

  // clock, 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // half l1 distance of the normalized histograms, unsigned q1.16
  function automatic logic [ahd_pkg::QUO_W-1:0] half_l1_q16();
    logic [127:0] sa, sb, acc, x, y, den, quo;
    int           i;
    sa  = '0;
    sb  = '0;
    acc = '0;
    for (i = 0; i < BIN_COUNT; i++) begin
      sa += bins_a[i];
      sb += bins_b[i];
    end
    if (sa == 0) sa = 1;
    if (sb == 0) sb = 1;
    for (i = 0; i < BIN_COUNT; i++) begin
      x = bins_a[i] * sb;
      y = bins_b[i] * sa;
      acc += (x >= y) ? x - y : y - x;
    end
    den = (sa * sb) << 1;
    quo = (acc << 16) / den;
    return quo[ahd_pkg::QUO_W-1:0];
  endfunction

  // update the predicted histograms and return the result of one item
  function automatic hist_result_t apply_item(logic [1:0] func, logic target,
                                              logic [ahd_pkg::ANGLE_W-1:0] angle,
                                              logic [ahd_pkg::WEIGHT_W-1:0] weight);
    hist_result_t            res;
    int unsigned             idx;
    logic [ahd_pkg::BIN_W:0] total;
    res = '{bin_index: '0, distance: '0, dist_valid: 1'b0};
    case (func)
      ahd_pkg::FUNC_ADD: begin
        idx = (32'(angle) * BIN_COUNT) >> 16;
        if (idx >= BIN_COUNT) idx = BIN_COUNT - 1;
        total = target ? {1'b0, bins_b[idx]} + weight : {1'b0, bins_a[idx]} + weight;
        if (total[ahd_pkg::BIN_W]) begin
          total = {1'b0, {ahd_pkg::BIN_W{1'b1}}};
          n_sat++;
        end
        if (target) bins_b[idx] = total[ahd_pkg::BIN_W-1:0];
        else bins_a[idx] = total[ahd_pkg::BIN_W-1:0];
        res.bin_index = ahd_pkg::IDX_W'(idx);
      end
      ahd_pkg::FUNC_CMP: begin
        res.distance   = half_l1_q16();
        res.dist_valid = 1'b1;
      end
      ahd_pkg::FUNC_CLR: begin
        for (int i = 0; i < BIN_COUNT; i++) begin
          bins_a[i] = '0;
          bins_b[i] = '0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic flag_error(input string what);
    errors++;
    if (errors <= 10) $display("error %0d: %s", errors, what);
  endtask

  function automatic hist_item_t make_item(logic [1:0] func, logic target,
                                           logic [ahd_pkg::ANGLE_W-1:0] angle,
                                           logic [ahd_pkg::WEIGHT_W-1:0] weight);
    return '{func: func, target: target, angle: angle, weight: weight,
             drain: 1'b0, steady: 1'b0};
  endfunction

  // mostly adds with the odd compare, clear or unused code
  function automatic hist_item_t random_item();
    hist_item_t                   it;
    int unsigned                  pick;
    logic [1:0]                   func;
    logic [ahd_pkg::ANGLE_W-1:0]  angle;
    logic [ahd_pkg::WEIGHT_W-1:0] weight;
    pick = $urandom_range(0, 99);
    if (pick < 84) func = ahd_pkg::FUNC_ADD;
    else if (pick < 94) func = ahd_pkg::FUNC_CMP;
    else if (pick < 97) func = ahd_pkg::FUNC_CLR;
    else func = FUNC_NONE;
    // angles on and next to bin edges now and then
    if ($urandom_range(0, 3) == 0)
      angle = ahd_pkg::ANGLE_W'($urandom_range(0, 15) << 12)
              - ahd_pkg::ANGLE_W'($urandom_range(0, 1));
    else angle = ahd_pkg::ANGLE_W'($urandom_range(0, 65535));
    case ($urandom_range(0, 3))
      0: weight = ahd_pkg::WEIGHT_W'($urandom_range(0, 15));
      1: weight = {ahd_pkg::WEIGHT_W{1'b1}};
      default: weight = ahd_pkg::WEIGHT_W'($urandom_range(0, 65535));
    endcase
    it = make_item(func, 1'($urandom_range(0, 1)), angle, weight);
    return it;
  endfunction

  // accept items, predict, check results, watchdog
  always @(posedge clk_i) begin : track_items
    hist_result_t want;
    if (rst_ni) begin
      idle_cycles++;
      // result side first, so an item accepted now cannot match itself
      if (out_valid_o && !out_stall_i) begin
        idle_cycles = 0;
        checked++;
        if (hist_results_q.size() == 0) begin
          flag_error($sformatf("unexpected result bin %0d dist %0d dvalid %0b",
                               bin_index_o, distance_o, distance_valid_o));
        end else begin
          want = hist_results_q.pop_front();
          if (bin_index_o !== want.bin_index)
            flag_error($sformatf("bin_index exp %0d got %0d", want.bin_index, bin_index_o));
          if (distance_o !== want.distance)
            flag_error($sformatf("distance exp %0d got %0d", want.distance, distance_o));
          if (distance_valid_o !== want.dist_valid)
            flag_error($sformatf("distance_valid exp %0b got %0b", want.dist_valid,
                                 distance_valid_o));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        idle_cycles = 0;
        in_took = 1'b1;
        case (func_i)
          ahd_pkg::FUNC_ADD: n_add++;
          ahd_pkg::FUNC_CMP: n_cmp++;
          ahd_pkg::FUNC_CLR: n_clr++;
          default:           n_none++;
        endcase
        hist_results_q.push_back(apply_item(func_i, target_i, angle_i, weight_i));
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", idle_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  // item driver, changes at the falling edge
  always @(negedge clk_i) begin : drive_items
    hist_item_t it;
    bit         hold;
    if (rst_ni) begin
      hold    = in_valid_i && !in_took;
      in_took = 1'b0;
      if (!hold) begin
        if (in_gap != 0 && !steady) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (angle_items_q.size() != 0 &&
                     !(angle_items_q[0].drain && hist_results_q.size() != 0)) begin
          if (!steady && !angle_items_q[0].steady && send_idle &&
              $urandom_range(0, 7) == 0) begin
            // this cycle is the first of the gap
            in_gap = $urandom_range(1, 7) - 1;
            in_valid_i <= 1'b0;
          end else begin
            it = angle_items_q.pop_front();
            if (it.steady) steady = 1'b1;
            in_valid_i <= 1'b1;
            func_i     <= it.func;
            target_i   <= it.target;
            angle_i    <= it.angle;
            weight_i   <= it.weight;
            sent++;
            if (sent % 100 == 0) send_idle = ($urandom_range(0, 3) != 0);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result stall in random bursts
  always @(negedge clk_i) begin : drive_stall
    if (!rst_ni || steady) begin
      stall_left = 0;
      out_stall_i <= 1'b0;
    end else begin
      if (stall_left == 0 && stall_idle && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 7);
      if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
      stall_tick++;
      if (stall_tick % 256 == 0) stall_idle = ($urandom_range(0, 3) != 0);
    end
  end

  // stimulus and end of run
  initial begin : run_test
    hist_item_t it;
    for (int i = 0; i < BIN_COUNT; i++) begin
      bins_a[i] = '0;
      bins_b[i] = '0;
    end

    // directed: empty compare, edges of angle and weight, disjoint and nearly equal shapes
    angle_items_q.push_back(make_item(ahd_pkg::FUNC_CMP, 1'b0, 16'h0000, 16'h0000));
    angle_items_q.push_back(make_item(FUNC_NONE, 1'b1, 16'hFFFF, 16'hFFFF));
    angle_items_q.push_back(make_item(ahd_pkg::FUNC_ADD, 1'b0, 16'h0000, 16'h0000));
    angle_items_q.push_back(make_item(ahd_pkg::FUNC_ADD, 1'b0, 16'hFFFF, 16'hFFFF));
    angle_items_q.push_back(make_item(ahd_pkg::FUNC_CMP, 1'b1, 16'hFFFF, 16'hFFFF));
    angle_items_q.push_back(make_item(ahd_pkg::FUNC_ADD, 1'b1, 16'h8000, 16'h0001));
    angle_items_q.push_back(make_item(ahd_pkg::FUNC_CMP, 1'b0, 16'h0000, 16'h0000));
    angle_items_q.push_back(make_item(ahd_pkg::FUNC_ADD, 1'b1, 16'h0FFF, 16'h8000));
    angle_items_q.push_back(make_item(ahd_pkg::FUNC_ADD, 1'b1, 16'h1000, 16'h7FFF));
    angle_items_q.push_back(make_item(ahd_pkg::FUNC_ADD, 1'b0, 16'h0FFF, 16'h8000));
    angle_items_q.push_back(make_item(ahd_pkg::FUNC_ADD, 1'b0, 16'h1000, 16'h7FFF));
    angle_items_q.push_back(make_item(ahd_pkg::FUNC_ADD, 1'b1, 16'hFFFF, 16'hFFFF));
    angle_items_q.push_back(make_item(ahd_pkg::FUNC_CMP, 1'b0, 16'h0000, 16'h0000));
    angle_items_q.push_back(make_item(ahd_pkg::FUNC_CLR, 1'b1, 16'hFFFF, 16'hFFFF));
    angle_items_q.push_back(make_item(ahd_pkg::FUNC_CMP, 1'b0, 16'h0000, 16'h0000));
    angle_items_q.push_back(make_item(ahd_pkg::FUNC_ADD, 1'b1, 16'hF000, 16'h1234));
    angle_items_q.push_back(make_item(ahd_pkg::FUNC_CMP, 1'b0, 16'h0000, 16'h0000));
    angle_items_q.push_back(make_item(FUNC_NONE, 1'b0, 16'h0000, 16'h0000));
    angle_items_q.push_back(make_item(ahd_pkg::FUNC_CMP, 1'b1, 16'h5555, 16'hAAAA));
    angle_items_q.push_back(make_item(ahd_pkg::FUNC_CLR, 1'b0, 16'h0000, 16'h0000));

    // random mix, with two points where the sender waits for all results
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      it = random_item();
      if (n == 600 || n == 1200) it.drain = 1'b1;
      angle_items_q.push_back(it);
    end

    // last part, no idling on either side
    it = make_item(ahd_pkg::FUNC_CLR, 1'b0, 16'h0000, 16'h0000);
    it.drain  = 1'b1;
    it.steady = 1'b1;
    angle_items_q.push_back(it);
    for (int n = 0; n < STEADY_ITEMS; n++) angle_items_q.push_back(random_item());
    angle_items_q.push_back(make_item(ahd_pkg::FUNC_CMP, 1'b0, 16'h0000, 16'h0000));

    // hold reset, then release it away from the sampling edge
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // drain everything, then give late results time to show up
    while (angle_items_q.size() != 0 || in_valid_i || hist_results_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (hist_results_q.size() != 0)
      flag_error($sformatf("%0d results never arrived", hist_results_q.size()));

    $display("covered %0d adds (%0d saturating), %0d compares, %0d clears, %0d unused codes",
             n_add, n_sat, n_cmp, n_clr, n_none);
    $display("checked %0d results, %0d errors", checked, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/ahd_pkg.sv
rtl/ahd_ram.sv
rtl/ahd_div.sv
rtl/angle_histogram_distance.sv
tb/sv/angle_histogram_distance_test.sv
